### src/mmis_pkg.sv
// ============================================================================
// mmis_pkg - shared codes, microword format and control store
// Opcode and status codes, the microinstruction layout and the read-only
// control program of the instruction step sequencer.
// ============================================================================
package mmis_pkg;

    // host operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_EXEC  = 2'd2;

    // instruction opcodes
    localparam logic [3:0] OPC_SET   = 4'd0;
    localparam logic [3:0] OPC_CPY   = 4'd1;
    localparam logic [3:0] OPC_CPYI  = 4'd2;
    localparam logic [3:0] OPC_CPYI2 = 4'd3;
    localparam logic [3:0] OPC_ADD   = 4'd4;
    localparam logic [3:0] OPC_ADDI  = 4'd5;
    localparam logic [3:0] OPC_SUBI  = 4'd6;
    localparam logic [3:0] OPC_JIF   = 4'd7;
    localparam logic [3:0] OPC_HLT   = 4'd8;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;
    localparam logic [1:0] ST_SYS   = 2'd3;

    typedef logic [4:0] upc_t;

    // control store entry points and steps
    localparam upc_t U_SYS    = 5'd0;
    localparam upc_t U_SET    = 5'd1;
    localparam upc_t U_INC    = 5'd2;
    localparam upc_t U_CPY    = 5'd3;
    localparam upc_t U_CPY_W  = 5'd4;
    localparam upc_t U_CPYI   = 5'd5;
    localparam upc_t U_CPYI_R = 5'd6;
    localparam upc_t U_CPYI_W = 5'd7;
    localparam upc_t U_CPI2   = 5'd8;
    localparam upc_t U_CPI2_R = 5'd9;
    localparam upc_t U_CPI2_W = 5'd10;
    localparam upc_t U_ADD    = 5'd11;
    localparam upc_t U_ADD_W  = 5'd12;
    localparam upc_t U_ADDI   = 5'd13;
    localparam upc_t U_ADDI_R = 5'd14;
    localparam upc_t U_ADDI_W = 5'd15;
    localparam upc_t U_SUBI   = 5'd16;
    localparam upc_t U_SUBI_R = 5'd17;
    localparam upc_t U_SUBI_W = 5'd18;
    localparam upc_t U_JIF    = 5'd19;
    localparam upc_t U_JIF_W  = 5'd20;
    localparam upc_t U_HLT    = 5'd21;
    localparam upc_t U_FAULT  = 5'd22;
    localparam upc_t U_STOP   = 5'd23;
    localparam upc_t U_HWR    = 5'd24;
    localparam upc_t U_HRD    = 5'd25;
    localparam upc_t U_HRD_Q  = 5'd26;
    localparam upc_t U_NONE   = 5'd27;

    typedef enum logic [1:0] { RS_A, RS_B, RS_Q, RS_HOST } rd_src_t;
    typedef enum logic [1:0] { CAP_NONE, CAP_T, CAP_D, CAP_OUT } cap_t;
    typedef enum logic [1:0] { WD_B, WD_D, WD_PC, WD_HOST } wr_dst_t;
    typedef enum logic [2:0] {
        WS_A, WS_Q, WS_QADDA, WS_TADDQ, WS_TSUBQ, WS_INC, WS_JIF, WS_HOST
    } wr_src_t;
    typedef enum logic [2:0] { SS_OK, SS_HALT, SS_FAULT, SS_SYS, SS_STOP } stat_sel_t;

    typedef struct packed {
        logic      rd_en;   // issue a memory read
        rd_src_t   rd_src;
        cap_t      cap;     // capture last read data
        logic      chk;     // last read data is an address: range check
        logic      wr_en;
        wr_dst_t   wr_dst;
        wr_src_t   wr_src;
        logic      wr_bnz;  // write only when operand B is nonzero
        logic      last;
        logic      cnt;     // counts as an executed instruction
        stat_sel_t stat;
        upc_t      nxt;
    } uword_t;

    function automatic uword_t ucode(input upc_t upc);
        uword_t w;
        w = '0;
        w.nxt = U_INC;
        case (upc)
            U_SYS:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_PC; w.wr_src = WS_INC;
                w.last = 1'b1; w.cnt = 1'b1; w.stat = SS_SYS;
            end
            U_SET:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_B; w.wr_src = WS_A;
            end
            U_INC:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_PC; w.wr_src = WS_INC; w.wr_bnz = 1'b1;
                w.last = 1'b1; w.cnt = 1'b1;
            end
            U_CPY:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_A; w.nxt = U_CPY_W;
            end
            U_CPY_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_B; w.wr_src = WS_Q;
            end
            U_CPYI:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_A; w.nxt = U_CPYI_R;
            end
            U_CPYI_R:
            begin
                w.chk = 1'b1; w.rd_en = 1'b1; w.rd_src = RS_Q; w.nxt = U_CPYI_W;
            end
            U_CPYI_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_B; w.wr_src = WS_Q;
            end
            U_CPI2:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_B; w.nxt = U_CPI2_R;
            end
            U_CPI2_R:
            begin
                w.chk = 1'b1; w.cap = CAP_D; w.rd_en = 1'b1; w.rd_src = RS_A;
                w.nxt = U_CPI2_W;
            end
            U_CPI2_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_D; w.wr_src = WS_Q;
            end
            U_ADD:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_B; w.nxt = U_ADD_W;
            end
            U_ADD_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_B; w.wr_src = WS_QADDA;
            end
            U_ADDI:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_A; w.nxt = U_ADDI_R;
            end
            U_ADDI_R:
            begin
                w.cap = CAP_T; w.rd_en = 1'b1; w.rd_src = RS_B; w.nxt = U_ADDI_W;
            end
            U_ADDI_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_B; w.wr_src = WS_TADDQ;
            end
            U_SUBI:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_A; w.nxt = U_SUBI_R;
            end
            U_SUBI_R:
            begin
                w.cap = CAP_T; w.rd_en = 1'b1; w.rd_src = RS_B; w.nxt = U_SUBI_W;
            end
            U_SUBI_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_B; w.wr_src = WS_TSUBQ;
            end
            U_JIF:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_A; w.nxt = U_JIF_W;
            end
            U_JIF_W:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_PC; w.wr_src = WS_JIF;
                w.last = 1'b1; w.cnt = 1'b1;
            end
            U_HLT:
            begin
                w.last = 1'b1; w.cnt = 1'b1; w.stat = SS_HALT;
            end
            U_FAULT:
            begin
                w.last = 1'b1; w.stat = SS_FAULT;
            end
            U_STOP:
            begin
                w.last = 1'b1; w.stat = SS_STOP;
            end
            U_HWR:
            begin
                w.wr_en = 1'b1; w.wr_dst = WD_HOST; w.wr_src = WS_HOST; w.last = 1'b1;
            end
            U_HRD:
            begin
                w.rd_en = 1'b1; w.rd_src = RS_HOST; w.nxt = U_HRD_Q;
            end
            U_HRD_Q:
            begin
                w.cap = CAP_OUT; w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    // first step of the program for one request
    function automatic upc_t entry_point(
        input logic [1:0] op,
        input logic       kind,
        input logic [3:0] opcode,
        input logic       stopped,
        input logic       a_ok,
        input logic       b_ok,
        input logic       host_ok
    );
        upc_t e;
        e = U_NONE;
        case (op)
            OP_WRITE: e = host_ok ? U_HWR : U_NONE;
            OP_READ:  e = host_ok ? U_HRD : U_NONE;
            OP_EXEC:
            begin
                if (stopped)
                    e = U_STOP;
                else if (kind)
                    e = U_SYS;
                else if (opcode == OPC_HLT)
                    e = U_HLT;
                else if (!b_ok || (!a_ok && opcode != OPC_SET && opcode != OPC_ADD))
                    e = U_FAULT;
                else
                begin
                    case (opcode)
                        OPC_SET:   e = U_SET;
                        OPC_CPY:   e = U_CPY;
                        OPC_CPYI:  e = U_CPYI;
                        OPC_CPYI2: e = U_CPI2;
                        OPC_ADD:   e = U_ADD;
                        OPC_ADDI:  e = U_ADDI;
                        OPC_SUBI:  e = U_SUBI;
                        OPC_JIF:   e = U_JIF;
                        default:   e = U_INC;
                    endcase
                end
            end
            default: e = U_NONE;
        endcase
        return e;
    endfunction

endpackage

### src/mmis_if.sv
// ============================================================================
// mmis_req_if / mmis_rsp_if - request and response channels
// Valid/ready channels carrying one request and one response each.
// ============================================================================
interface mmis_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         address;
    logic signed [31:0] write_value;
    logic               instr_kind;
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         call_number;

    modport source (output valid, op, address, write_value, instr_kind, opcode,
                    operand_a, operand_b, call_number, input ready);
    modport sink   (input valid, op, address, write_value, instr_kind, opcode,
                    operand_a, operand_b, call_number, output ready);
endinterface

interface mmis_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] program_counter;
    logic signed [31:0] read_value;
    logic [2:0]         call_out;
    logic signed [31:0] call_argument;
    logic [31:0]        step_count;

    modport source (output valid, status, program_counter, read_value, call_out,
                    call_argument, step_count, input ready);
    modport sink   (input valid, status, program_counter, read_value, call_out,
                    call_argument, step_count, output ready);
endinterface

### src/mmis_ram.sv
// ============================================================================
// mmis_ram - single-port data memory
// One address per cycle, write or registered read.
// ============================================================================
module mmis_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end

endmodule

### src/memory_machine_instruction_step.sv
// ============================================================================
// memory_machine_instruction_step - one step of a memory-to-memory machine
// Executes one instruction, host write or host read per request against a
// word memory whose word 0 is the program counter.
// ============================================================================
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  req     | in  | valid / ready | op, address, write_value, instr_kind,
//          |     |               | opcode, operand_a, operand_b, call_number
//  rsp     | out | valid / ready | status, program_counter, read_value,
//          |     |               | call_out, call_argument, step_count
//
//  One request at a time. A request is accepted, then runs its microcode
//  steps; the single-port data memory with its registered read sets the
//  step count: one access per step.
//  Reset clears control state, stop/fault flags, the step counter and the PC
//  copy; memory contents are undefined until written.
//  A full response register holds the sequencer on its final step; req.ready
//  returns as soon as the response is registered.
//
module memory_machine_instruction_step
    import mmis_pkg::*;
#(
    parameter int MEM_WORDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    mmis_req_if.sink    req,
    mmis_rsp_if.source  rsp
);

    localparam int          AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

    // ---------------- control state ----------------
    logic        busy_reg,    busy_next;
    upc_t        upc_reg,     upc_next;
    logic        stopped_reg, stopped_next;
    logic        faulted_reg, faulted_next;
    logic [31:0] cnt_reg,     cnt_next;
    logic [31:0] pc_reg,      pc_next;    // copy of memory word 0
    logic        rsp_valid_reg, rsp_valid_next;

    // ---------------- request payload ----------------
    logic [AW-1:0] addr_reg;
    logic [31:0]   wval_reg;
    logic [31:0]   a_reg;
    logic [31:0]   b_reg;
    logic [2:0]    call_reg;

    // ---------------- work registers ----------------
    logic [31:0]   t_reg;     // first operand of addi/subi
    logic [AW-1:0] d_reg;     // indirect destination of cpyi2

    // ---------------- response payload ----------------
    logic [1:0]    status_reg;
    logic [31:0]   pc_out_reg;
    logic [31:0]   rdval_reg;
    logic [2:0]    cout_reg;
    logic [31:0]   carg_reg;
    logic [31:0]   step_reg;

    uword_t        uw;
    logic [31:0]   mem_q;
    logic          accept;
    logic          chk_fail;
    logic          done;
    logic          fire;
    logic          wr_do;
    logic          rd_do;
    logic          jif_take;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] ram_addr;
    logic [31:0]   wdata;
    logic          a_ok;
    logic          b_ok;
    logic          host_ok;
    logic [1:0]    status_now;

    // request acceptance and entry decode
    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign a_ok      = $unsigned(req.operand_a) < MEM_LIMIT;
    assign b_ok      = $unsigned(req.operand_b) < MEM_LIMIT;
    assign host_ok   = 32'(req.address) < MEM_LIMIT;

    // control word of the current step
    assign uw = ucode(upc_reg);

    // An indirect address read in the previous step is checked here; a bad
    // one ends the program as a fault with no write and no count.
    assign chk_fail = uw.chk && (mem_q >= MEM_LIMIT);
    assign done     = uw.last || chk_fail;
    // hold the final step while the response register is still occupied
    assign fire     = busy_reg && !(done && rsp_valid_reg && !rsp.ready);
    assign wr_do    = fire && uw.wr_en && !chk_fail && (!uw.wr_bnz || (b_reg != '0));
    assign rd_do    = fire && uw.rd_en;
    // jif branches when the word is zero or negative
    assign jif_take = (mem_q == '0) || mem_q[31];

    always_comb
    begin
        case (uw.rd_src)
            RS_A:    rd_idx = AW'(a_reg);
            RS_B:    rd_idx = AW'(b_reg);
            RS_Q:    rd_idx = AW'(mem_q);
            RS_HOST: rd_idx = addr_reg;
            default: rd_idx = addr_reg;
        endcase
    end

    always_comb
    begin
        case (uw.wr_dst)
            WD_B:    wr_idx = AW'(b_reg);
            WD_D:    wr_idx = d_reg;
            WD_PC:   wr_idx = '0;
            WD_HOST: wr_idx = addr_reg;
            default: wr_idx = '0;
        endcase
    end

    always_comb
    begin
        case (uw.wr_src)
            WS_A:     wdata = a_reg;
            WS_Q:     wdata = mem_q;
            WS_QADDA: wdata = mem_q + a_reg;
            WS_TADDQ: wdata = t_reg + mem_q;
            WS_TSUBQ: wdata = t_reg - mem_q;
            WS_INC:   wdata = pc_reg + 32'd1;
            WS_JIF:   wdata = jif_take ? b_reg : (pc_reg + 32'd1);
            WS_HOST:  wdata = wval_reg;
            default:  wdata = wval_reg;
        endcase
    end

    assign ram_addr = uw.wr_en ? wr_idx : rd_idx;

    mmis_ram #(
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_do),
        .re    (rd_do),
        .addr  (ram_addr),
        .wdata (wdata),
        .rdata (mem_q)
    );

    // response status of the finishing step
    always_comb
    begin
        if (chk_fail)
            status_now = ST_FAULT;
        else
        begin
            case (uw.stat)
                SS_OK:    status_now = ST_OK;
                SS_HALT:  status_now = ST_HALT;
                SS_FAULT: status_now = ST_FAULT;
                SS_SYS:   status_now = ST_SYS;
                SS_STOP:  status_now = faulted_reg ? ST_FAULT : ST_HALT;
                default:  status_now = ST_OK;
            endcase
        end
    end

    // next state of the sequencer and the machine flags
    always_comb
    begin
        busy_next      = busy_reg;
        upc_next       = upc_reg;
        stopped_next   = stopped_reg;
        faulted_next   = faulted_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        // PC copy tracks every write to word 0
        pc_next        = (wr_do && (wr_idx == '0)) ? wdata : pc_reg;

        if (accept)
        begin
            busy_next = 1'b1;
            upc_next  = entry_point(req.op, req.instr_kind, req.opcode, stopped_reg,
                                    a_ok, b_ok, host_ok);
        end
        else if (fire)
        begin
            if (done)
            begin
                busy_next      = 1'b0;
                rsp_valid_next = 1'b1;
                if (uw.cnt && !chk_fail)
                    cnt_next = cnt_reg + 32'd1;
                if (chk_fail || uw.stat == SS_FAULT)
                begin
                    stopped_next = 1'b1;
                    faulted_next = 1'b1;
                end
                if (uw.stat == SS_HALT)
                    stopped_next = 1'b1;
            end
            else
                upc_next = uw.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            upc_reg       <= U_NONE;
            stopped_reg   <= 1'b0;
            faulted_reg   <= 1'b0;
            cnt_reg       <= '0;
            pc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            stopped_reg   <= stopped_next;
            faulted_reg   <= faulted_next;
            cnt_reg       <= cnt_next;
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= AW'(req.address);
            wval_reg <= req.write_value;
            a_reg    <= req.operand_a;
            b_reg    <= req.operand_b;
            call_reg <= req.call_number;
        end
        if (fire && uw.cap == CAP_T)
            t_reg <= mem_q;
        if (fire && uw.cap == CAP_D)
            d_reg <= AW'(mem_q);
        if (fire && done)
        begin
            status_reg <= status_now;
            pc_out_reg <= pc_next;
            rdval_reg  <= (uw.cap == CAP_OUT) ? mem_q : '0;
            cout_reg   <= (status_now == ST_SYS) ? call_reg : '0;
            carg_reg   <= (status_now == ST_SYS) ? a_reg : '0;
            step_reg   <= cnt_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.program_counter = pc_out_reg;
    assign rsp.read_value      = rdval_reg;
    assign rsp.call_out        = cout_reg;
    assign rsp.call_argument   = carg_reg;
    assign rsp.step_count      = step_reg;

endmodule

### src/mmis_checker.sv
// ============================================================================
// mmis_checker - port-level checks for the instruction step block
// Watches the request and response ports; bound to the top level.
// ============================================================================
module mmis_checker
    import mmis_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [31:0] read_value,
    input logic [2:0]  call_out,
    input logic [31:0] call_argument
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_value))
        else $error("response dropped or changed while stalled");

    // one request in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // call fields only carry data on a system call
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_SYS |-> call_out == '0 && call_argument == '0)
        else $error("call fields set without a system call");

    // read data only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> read_value == '0)
        else $error("read data on a non-ok response");

endmodule

bind memory_machine_instruction_step mmis_checker u_mmis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .read_value    (rsp.read_value),
    .call_out      (rsp.call_out),
    .call_argument (rsp.call_argument)
);

### bench/memory_machine_instruction_step_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// memory_machine_instruction_step_tb - self-checking bench for the step block
// Drives host writes, host reads and instructions over the request channel,
// mirrors data memory, stop state and step count, and checks each response
// in order against the mirrored machine. Both channels idle at random.
// ============================================================================
module memory_machine_instruction_step_tb;
    import mmis_pkg::*;

    localparam int         MEM_WORDS  = 256;
    localparam logic [1:0] OP_UNUSED  = 2'd3;   // host op code the block answers without acting on
    localparam int         MAX_REPORT = 10;

    // one request as it crosses the req channel
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  address;
        logic [31:0] write_value;
        logic        instr_kind;
        logic [3:0]  opcode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [2:0]  call_number;
    } step_request_t;

    // one response as it crosses the rsp channel
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] program_counter;
        logic [31:0] read_value;
        logic [2:0]  call_out;
        logic [31:0] call_argument;
        logic [31:0] step_count;
    } step_response_t;

    // ------------------------------------------------------------------------
    // Machine mirror: own copy of memory, stop/fault flags and step counter.
    // apply_request() advances it per accepted request and queues the answer;
    // check_response() compares the oldest queued answer with the block.
    // ------------------------------------------------------------------------
    class machine_mirror;
        logic [31:0]    mem [MEM_WORDS];
        bit             stopped;
        bit             faulted;
        logic [31:0]    executed;
        step_response_t expected_steps [$];
        int unsigned    failures;

        function new();
            stopped  = 1'b0;
            faulted  = 1'b0;
            executed = '0;
            failures = 0;
        endfunction

        function bit in_range(logic [31:0] v);
            return v < MEM_WORDS;
        endfunction

        // address check of an ordinary instruction on a running machine
        function bit faults(step_request_t r);
            if (r.instr_kind || r.opcode == OPC_HLT)
                return 1'b0;
            if (!in_range(r.operand_b))
                return 1'b1;
            if (!in_range(r.operand_a) && r.opcode != OPC_SET && r.opcode != OPC_ADD)
                return 1'b1;
            if (r.opcode == OPC_CPYI && !in_range(mem[r.operand_a[7:0]]))
                return 1'b1;
            if (r.opcode == OPC_CPYI2 && !in_range(mem[r.operand_b[7:0]]))
                return 1'b1;
            return 1'b0;
        endfunction

        function void apply_request(step_request_t r);
            step_response_t e;
            logic [7:0]     ia;
            logic [7:0]     ib;
            logic [31:0]    va;
            e  = '0;
            ia = r.operand_a[7:0];
            ib = r.operand_b[7:0];
            case (r.op)
                OP_WRITE: mem[r.address] = r.write_value;
                OP_READ:  e.read_value = mem[r.address];
                OP_EXEC:
                begin
                    if (stopped)
                        e.status = faulted ? ST_FAULT : ST_HALT;
                    else if (r.instr_kind)
                    begin
                        e.status        = ST_SYS;
                        e.call_out      = r.call_number;
                        e.call_argument = r.operand_a;
                        mem[0]          = mem[0] + 1;
                        executed        = executed + 1;
                    end
                    else if (faults(r))
                    begin
                        stopped  = 1'b1;
                        faulted  = 1'b1;
                        e.status = ST_FAULT;
                    end
                    else
                    begin
                        case (r.opcode)
                            OPC_SET:   mem[ib] = r.operand_a;
                            OPC_CPY:   mem[ib] = mem[ia];
                            OPC_CPYI:  mem[ib] = mem[mem[ia][7:0]];
                            OPC_CPYI2: mem[mem[ib][7:0]] = mem[ia];
                            OPC_ADD:   mem[ib] = mem[ib] + r.operand_a;
                            OPC_ADDI:  mem[ib] = mem[ib] + mem[ia];
                            OPC_SUBI:  mem[ib] = mem[ia] - mem[ib];
                            OPC_JIF:
                            begin
                                va     = mem[ia];
                                mem[0] = (va == 0 || va[31]) ? r.operand_b : mem[0] + 1;
                            end
                            OPC_HLT:
                            begin
                                stopped  = 1'b1;
                                e.status = ST_HALT;
                            end
                            default: ;
                        endcase
                        if (r.opcode != OPC_JIF && r.opcode != OPC_HLT && r.operand_b != 0)
                            mem[0] = mem[0] + 1;
                        executed = executed + 1;
                    end
                end
                default: ;
            endcase
            e.program_counter = mem[0];
            e.step_count      = executed;
            expected_steps.push_back(e);
        endfunction

        function void check_response(step_response_t got);
            step_response_t exp;
            bit             ok;
            if (expected_steps.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORT)
                    $display("%0t: response with no request outstanding: st=%0d pc=%h",
                             $realtime, got.status, got.program_counter);
                return;
            end
            exp = expected_steps.pop_front();
            ok  = (got.status === exp.status)
               && (got.program_counter === exp.program_counter)
               && (got.read_value === exp.read_value)
               && (got.call_out === exp.call_out)
               && (got.call_argument === exp.call_argument)
               && (got.step_count === exp.step_count);
            if (!ok)
            begin
                failures++;
                if (failures <= MAX_REPORT)
                    $display("%0t: mismatch exp st=%0d pc=%h rd=%h co=%0d ca=%h cnt=%0d",
                             $realtime, exp.status, exp.program_counter, exp.read_value,
                             exp.call_out, exp.call_argument, exp.step_count,
                             "\n            got st=%0d pc=%h rd=%h co=%0d ca=%h cnt=%0d",
                             got.status, got.program_counter, got.read_value,
                             got.call_out, got.call_argument, got.step_count);
            end
        endfunction

        // answers still owed at the end are failures
        function void flush_leftovers();
            while (expected_steps.size() != 0)
            begin
                void'(expected_steps.pop_front());
                failures++;
                if (failures <= MAX_REPORT)
                    $display("%0t: response never arrived", $realtime);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    mmis_req_if req_ch ();
    mmis_rsp_if rsp_ch ();

    memory_machine_instruction_step #(
        .MEM_WORDS (MEM_WORDS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    machine_mirror mirror = new();

    // quiet: both sides drop their idle cycles for a stretch of requests
    bit          quiet = 1'b0;
    int unsigned accepted_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request helpers
    // ------------------------------------------------------------------------

    // every field random, so fields a request does not use still toggle
    function automatic step_request_t random_fill();
        step_request_t r;
        r.op          = 2'($urandom_range(0, 3));
        r.address     = 8'($urandom);
        r.write_value = $urandom;
        r.instr_kind  = 1'($urandom_range(0, 1));
        r.opcode      = 4'($urandom_range(0, 15));
        r.operand_a   = $urandom;
        r.operand_b   = $urandom;
        r.call_number = 3'($urandom_range(0, 7));
        return r;
    endfunction

    // mostly small words so indirect operands stay usable
    function automatic logic [31:0] random_word();
        if ($urandom_range(0, 99) < 65)
            return $urandom_range(0, MEM_WORDS - 1);
        return $urandom;
    endfunction

    // Drive one request and hold it until accepted. The gap before it is
    // drawn per request; valid drops only when a gap is actually taken.
    task automatic send_request(step_request_t r);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= r.op;
        req_ch.address     <= r.address;
        req_ch.write_value <= r.write_value;
        req_ch.instr_kind  <= r.instr_kind;
        req_ch.opcode      <= r.opcode;
        req_ch.operand_a   <= r.operand_a;
        req_ch.operand_b   <= r.operand_b;
        req_ch.call_number <= r.call_number;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // mirror is updated here, before the next request is built from it
        mirror.apply_request(r);
        accepted_count++;
        if (accepted_count % 50 == 0)
            quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic host_write(logic [7:0] addr, logic [31:0] value);
        step_request_t r;
        r             = random_fill();
        r.op          = OP_WRITE;
        r.address     = addr;
        r.write_value = value;
        send_request(r);
    endtask

    task automatic host_read(logic [7:0] addr);
        step_request_t r;
        r         = random_fill();
        r.op      = OP_READ;
        r.address = addr;
        send_request(r);
    endtask

    task automatic run_instr(logic kind, logic [3:0] opc, logic [31:0] a, logic [31:0] b);
        step_request_t r;
        r            = random_fill();
        r.op         = OP_EXEC;
        r.instr_kind = kind;
        r.opcode     = opc;
        r.operand_a  = a;
        r.operand_b  = b;
        send_request(r);
    endtask

    // Well-formed ordinary instruction: never hlt, never faults against the
    // current mirror, so the machine keeps running through the random part.
    function automatic step_request_t make_instruction();
        step_request_t r;
        r            = random_fill();
        r.op         = OP_EXEC;
        r.instr_kind = 1'b0;
        for (int t = 0; t < 8; t++)
        begin
            if ($urandom_range(0, 99) < 85)
                r.opcode = 4'($urandom_range(OPC_SET, OPC_JIF));
            else
                r.opcode = 4'($urandom_range(9, 15));
            if ((r.opcode == OPC_SET || r.opcode == OPC_ADD) && $urandom_range(0, 1))
                r.operand_a = $urandom;
            else
                r.operand_a = $urandom_range(0, MEM_WORDS - 1);
            // destination 0 is the program counter itself
            r.operand_b = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(0, MEM_WORDS - 1);
            if (!mirror.faults(r))
                return r;
        end
        r.opcode    = OPC_SET;
        r.operand_b = $urandom_range(0, MEM_WORDS - 1);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus phases
    // ------------------------------------------------------------------------

    // Memory is undefined until written, so every word is loaded first;
    // word 0 goes first since each response reports it.
    task automatic preload_memory();
        logic [31:0] v;
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            v = random_word();
            if (i % 37 == 36)
                case ($urandom_range(0, 2))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    default: v = 32'hffff_ffff;
                endcase
            host_write(8'(i), v);
        end
    endtask

    task automatic directed_steps();
        host_write(10, 20);
        host_write(11, 30);
        host_write(20, 32'h7fff_ffff);
        run_instr(1'b0, OPC_SET,   32'h8000_0000, 12);  // immediate out of range is fine
        run_instr(1'b0, OPC_SET,   99, 0);              // writes PC, no advance
        run_instr(1'b0, OPC_CPY,   20, 13);
        run_instr(1'b0, OPC_CPYI,  10, 14);
        run_instr(1'b0, OPC_CPYI2, 20, 11);
        run_instr(1'b0, OPC_ADD,   1, 20);              // wraps past max positive
        run_instr(1'b0, OPC_ADD,   32'hffff_ffff, 10);  // negative immediate
        run_instr(1'b0, OPC_ADDI,  20, 13);
        run_instr(1'b0, OPC_SUBI,  10, 12);
        host_write(15, 0);
        run_instr(1'b0, OPC_JIF,   15, 40);             // zero: taken
        host_write(16, 32'hffff_ffff);
        run_instr(1'b0, OPC_JIF,   16, 255);            // negative: taken
        host_write(17, 5);
        run_instr(1'b0, OPC_JIF,   17, 3);              // positive: falls through
        // system calls skip the address check, even with an hlt opcode
        run_instr(1'b1, OPC_HLT,   32'h8000_0000, 32'hffff_ffff);
        run_instr(1'b1, OPC_SET,   32'h7fff_ffff, 32'h8000_0000);
        run_instr(1'b0, 4'd15,     255, 255);           // unknown opcode
        run_instr(1'b0, 4'd9,      0, 0);
        host_read(20);
        host_read(0);
    endtask

    task automatic random_steps(int unsigned target);
        step_request_t r;
        int unsigned   counted;
        int unsigned   pick;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                host_write(8'($urandom), random_word());
            else if (pick < 28)
                host_read(8'($urandom));
            else if (pick < 31)
            begin
                r    = random_fill();
                r.op = OP_UNUSED;
                send_request(r);
                continue;   // answered but not acted on by the block, not counted
            end
            else if (pick < 41)
                run_instr(1'b1, 4'($urandom), $urandom, $urandom);
            else
                send_request(make_instruction());
            counted++;
        end
    endtask

    // The machine stops for good, so exactly one stop cause is drawn per run.
    task automatic stop_machine();
        logic [3:0] opc;
        logic [7:0] slot;
        slot = 8'($urandom_range(1, MEM_WORDS - 1));
        case ($urandom_range(0, 4))
            0: run_instr(1'b0, OPC_HLT, $urandom, $urandom);
            1:
            begin
                // destination out of range, any opcode but hlt
                do opc = 4'($urandom_range(0, 15)); while (opc == OPC_HLT);
                run_instr(1'b0, opc, $urandom,
                          $urandom_range(0, 1) ? $urandom_range(MEM_WORDS, 32'h7fff_ffff)
                                               : $urandom_range(32'h8000_0000, 32'hffff_ffff));
            end
            2:
            begin
                // source out of range on any opcode but hlt, set and add
                do opc = 4'($urandom_range(0, 15));
                while (opc == OPC_HLT || opc == OPC_SET || opc == OPC_ADD);
                run_instr(1'b0, opc, $urandom_range(MEM_WORDS, 32'hffff_ffff),
                          $urandom_range(0, MEM_WORDS - 1));
            end
            3:
            begin
                host_write(slot, $urandom_range(MEM_WORDS, 32'hffff_ffff));
                run_instr(1'b0, OPC_CPYI, slot, $urandom_range(0, MEM_WORDS - 1));
            end
            default:
            begin
                host_write(slot, $urandom_range(MEM_WORDS, 32'hffff_ffff));
                run_instr(1'b0, OPC_CPYI2, $urandom_range(0, MEM_WORDS - 1), slot);
            end
        endcase
    endtask

    // once stopped: instructions answer the stop status, host access still works
    task automatic stopped_steps();
        step_request_t r;
        for (int i = 0; i < 14; i++)
        begin
            r = random_fill();
            case ($urandom_range(0, 3))
                0:       r.op = OP_EXEC;
                1:       r.op = OP_WRITE;
                2:       r.op = OP_READ;
                default: r.op = OP_UNUSED;
            endcase
            send_request(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: per response a random stall, then ready until taken
    // ------------------------------------------------------------------------
    initial
    begin
        step_response_t got;
        int unsigned    stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.status          = rsp_ch.status;
            got.program_counter = rsp_ch.program_counter;
            got.read_value      = rsp_ch.read_value;
            got.call_out        = rsp_ch.call_out;
            got.call_argument   = rsp_ch.call_argument;
            got.step_count      = rsp_ch.step_count;
            mirror.check_response(got);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_WRITE;
        req_ch.address     = '0;
        req_ch.write_value = '0;
        req_ch.instr_kind  = 1'b0;
        req_ch.opcode      = OPC_SET;
        req_ch.operand_a   = '0;
        req_ch.operand_b   = '0;
        req_ch.call_number = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        preload_memory();
        directed_steps();
        random_steps(700);
        stop_machine();
        stopped_steps();
        req_ch.valid <= 1'b0;

        // drain, then wait on for stray responses before the leftover check
        for (int i = 0; i < 2000 && mirror.expected_steps.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        mirror.flush_leftovers();

        if (mirror.failures == 0)
            $display("memory_machine_instruction_step verification clean");
        else
            $display("memory_machine_instruction_step verification failed");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("memory_machine_instruction_step verification failed");
        $finish;
    end

endmodule
